// ===== rtl/fdmd_pkg.sv =====
`timescale 1ns / 1ps

package fdmd_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam int ADDR_W    = $clog2(STORE_DEPTH);
    localparam int TOTAL_W   = $clog2(STORE_DEPTH + 1);
    localparam int COUNT_W   = 18;
    localparam int PIX_W     = 8;
    localparam int WIDTH_W   = 10;
    localparam int HEIGHT_W  = 9;
    localparam int TRIG_W    = 17;
    localparam int PERSIST_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;
    localparam int RHS_W     = TOTAL_W + TRIG_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PIX_THRESH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 3'd5;

    // Reset values
    localparam logic                 RST_COLOUR_MODE = 1'b1;
    localparam logic [WIDTH_W-1:0]   RST_WIDTH       = 10'd320;
    localparam logic [HEIGHT_W-1:0]  RST_HEIGHT      = 9'd240;
    localparam logic [PIX_W-1:0]     RST_THRESH      = 8'd25;
    localparam logic [TRIG_W-1:0]    RST_TRIGGER     = 17'd3277;
    localparam logic [PERSIST_W-1:0] RST_PERSISTENCE = 16'd1;

    // Cycles that derived size products need after a configuration write
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    // End-of-frame summary handed to the decision stage
    typedef struct packed {
        logic               valid;
        logic               compared;
        logic [COUNT_W-1:0] count;
    } fin_t;

endpackage

// ===== rtl/frame_difference_motion_detector.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid / s_tready       pixel: blue, green, red
// m_*       out        m_tvalid / m_tready       frame result: alarm, changed_count, compared
// cfg_*     in         cfg_valid / cfg_ready     register write: index, data
//
// Within a frame one pixel is taken per cycle while no configuration write holds
// input off; the frame store is read when a pixel enters and written once it has
// passed the a and b stage registers, so the memory ports set the rate. After the
// last pixel of a frame no pixel is taken until its result has left the output
// register, so an output stall also holds input off. After reset and after each
// configuration write, input is held off while the settle counter runs down.
module frame_difference_motion_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // blue [7:0], green [15:8], red [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // alarm [0], changed_count [18:1], zero [23:19]
    output logic        m_tuser,   // compared
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import fdmd_pkg::*;

    localparam logic [WIDTH_W-1:0]  MAX_W_V = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] MAX_H_V = HEIGHT_W'(MAX_HEIGHT);

    // Configuration
    logic                 colour_mode_reg;
    logic [WIDTH_W-1:0]   width_reg;
    logic [HEIGHT_W-1:0]  height_reg;
    logic [PIX_W-1:0]     thresh_reg;
    logic [TRIG_W-1:0]    trigger_reg;
    logic [PERSIST_W-1:0] persist_reg;
    logic [1:0]           settle_reg;
    logic [1:0]           settle_next;
    logic                 cfg_accept;
    logic                 forget;

    logic [WIDTH_W-1:0]          width_eff;
    logic [HEIGHT_W-1:0]         height_eff;
    logic [WIDTH_W+HEIGHT_W-1:0] area;
    logic [TOTAL_W-1:0]          total_reg;

    // Pixel flow
    logic                 accept;
    logic                 pending_last;
    logic [ADDR_W-1:0]    pos_reg;
    logic [TOTAL_W-1:0]   pos_inc;
    logic                 in_last;

    logic                 a_valid_reg;
    logic                 a_last_reg;
    logic [ADDR_W-1:0]    a_addr_reg;
    logic                 b_valid_reg;
    logic                 b_last_reg;
    logic [ADDR_W-1:0]    b_addr_reg;
    logic [PIX_W-1:0]     b_gray_reg;
    logic [PIX_W-1:0]     b_old_reg;

    logic [PIX_W-1:0]     gray;
    logic [PIX_W-1:0]     store_rdata;
    logic [PIX_W-1:0]     diff;
    logic                 changed;
    logic [COUNT_W-1:0]   tally_reg;
    logic [COUNT_W-1:0]   tally_sum;
    logic                 have_prev_reg;
    fin_t                 fin_reg;

    logic                 out_alarm;
    logic [COUNT_W-1:0]   out_count;
    logic                 out_compared;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign forget     = cfg_accept &&
                        ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_mode_reg <= RST_COLOUR_MODE;
            width_reg       <= RST_WIDTH;
            height_reg      <= RST_HEIGHT;
            thresh_reg      <= RST_THRESH;
            trigger_reg     <= RST_TRIGGER;
            persist_reg     <= RST_PERSISTENCE;
        end
        else if (cfg_accept)
        begin
            unique case (cfg_index)
                REG_COLOUR_MODE:  colour_mode_reg <= cfg_data[0];
                REG_FRAME_WIDTH:  width_reg       <= cfg_data[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: height_reg      <= cfg_data[HEIGHT_W-1:0];
                REG_PIX_THRESH:   thresh_reg      <= cfg_data[PIX_W-1:0];
                REG_TRIGGER:      trigger_reg     <= cfg_data[TRIG_W-1:0];
                REG_PERSISTENCE:  persist_reg     <= cfg_data[PERSIST_W-1:0];
                default:          ;
            endcase
        end
    end

    // Hold input while the size products catch up with a new setting
    always_comb
    begin
        settle_next = settle_reg;
        if (cfg_accept)
        begin
            settle_next = SETTLE_CYCLES;
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_CYCLES;
        end
        else
        begin
            settle_reg <= settle_next;
        end
    end

    assign width_eff  = (width_reg == '0)  ? WIDTH_W'(1)  :
                        (width_reg > MAX_W_V)  ? MAX_W_V : width_reg;
    assign height_eff = (height_reg == '0) ? HEIGHT_W'(1) :
                        (height_reg > MAX_H_V) ? MAX_H_V : height_reg;
    assign area       = (WIDTH_W+HEIGHT_W)'(width_eff) * (WIDTH_W+HEIGHT_W)'(height_eff);

    always_ff @(posedge clk)
    begin
        total_reg <= TOTAL_W'(area);
    end

    // Block new pixels while a frame's last pixel or its result is in flight
    assign pending_last = (a_valid_reg && a_last_reg) || (b_valid_reg && b_last_reg) ||
                          fin_reg.valid || m_tvalid;
    assign s_tready     = (settle_reg == '0) && !pending_last;
    assign accept       = s_tvalid && s_tready;

    assign pos_inc = {1'b0, pos_reg} + TOTAL_W'(1);
    assign in_last = (pos_inc >= total_reg);

    fdmd_gray u_gray (
        .clk         (clk),
        .en          (accept),
        .colour_mode (colour_mode_reg),
        .blue        (s_tdata[7:0]),
        .green       (s_tdata[15:8]),
        .red         (s_tdata[23:16]),
        .gray        (gray)
    );

    fdmd_store u_store (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_addr_reg),
        .wdata (b_gray_reg),
        .re    (accept),
        .raddr (pos_reg),
        .rdata (store_rdata)
    );

    assign diff      = (b_gray_reg > b_old_reg) ? (b_gray_reg - b_old_reg) :
                                                  (b_old_reg - b_gray_reg);
    assign changed   = have_prev_reg && (diff > thresh_reg);
    assign tally_sum = tally_reg + COUNT_W'(changed);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            tally_reg     <= '0;
            have_prev_reg <= 1'b0;
            fin_reg       <= '0;
        end
        else
        begin
            a_valid_reg   <= accept;
            b_valid_reg   <= a_valid_reg;
            fin_reg.valid <= 1'b0;

            if (forget)
            begin
                pos_reg       <= '0;
                tally_reg     <= '0;
                have_prev_reg <= 1'b0;
            end
            else
            begin
                if (accept)
                begin
                    pos_reg <= in_last ? '0 : pos_inc[ADDR_W-1:0];
                end
                if (b_valid_reg)
                begin
                    if (b_last_reg)
                    begin
                        tally_reg        <= '0;
                        have_prev_reg    <= 1'b1;
                        fin_reg.valid    <= 1'b1;
                        fin_reg.compared <= have_prev_reg;
                        fin_reg.count    <= have_prev_reg ? tally_sum : '0;
                    end
                    else
                    begin
                        tally_reg <= tally_sum;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_last_reg <= in_last;
            a_addr_reg <= pos_reg;
        end
        if (a_valid_reg)
        begin
            b_last_reg <= a_last_reg;
            b_addr_reg <= a_addr_reg;
            b_gray_reg <= gray;
            b_old_reg  <= store_rdata;
        end
    end

    fdmd_judge u_judge (
        .clk           (clk),
        .rst_n         (rst_n),
        .trigger       (trigger_reg),
        .total         (total_reg),
        .persistence   (persist_reg),
        .fin           (fin_reg),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .alarm         (out_alarm),
        .changed_count (out_count),
        .compared      (out_compared)
    );

    assign m_tdata = {5'b00000, out_count, out_alarm};
    assign m_tuser = out_compared;

endmodule

// ===== rtl/fdmd_gray.sv =====
`timescale 1ns / 1ps

module fdmd_gray (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     colour_mode,
    input  logic [fdmd_pkg::PIX_W-1:0] blue,
    input  logic [fdmd_pkg::PIX_W-1:0] green,
    input  logic [fdmd_pkg::PIX_W-1:0] red,
    output logic [fdmd_pkg::PIX_W-1:0] gray
);
    import fdmd_pkg::*;

    logic [18:0]      prod_b_reg;
    logic [21:0]      prod_g_reg;
    logic [20:0]      prod_r_reg;
    logic [PIX_W-1:0] blue_reg;
    logic             mode_reg;
    logic [21:0]      luma_sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_b_reg <= 19'(blue)  * 19'd1868;
            prod_g_reg <= 22'(green) * 22'd9617;
            prod_r_reg <= 21'(red)   * 21'd4899;
            blue_reg   <= blue;
            mode_reg   <= colour_mode;
        end
    end

    // Round and drop the Q14 fraction
    assign luma_sum = {3'b000, prod_b_reg} + prod_g_reg + {1'b0, prod_r_reg} + 22'd8192;
    assign gray     = mode_reg ? luma_sum[21:14] : blue_reg;

endmodule

// ===== rtl/fdmd_store.sv =====
`timescale 1ns / 1ps

module fdmd_store (
    input  logic                        clk,
    input  logic                        we,
    input  logic [fdmd_pkg::ADDR_W-1:0] waddr,
    input  logic [fdmd_pkg::PIX_W-1:0]  wdata,
    input  logic                        re,
    input  logic [fdmd_pkg::ADDR_W-1:0] raddr,
    output logic [fdmd_pkg::PIX_W-1:0]  rdata
);
    import fdmd_pkg::*;

    logic [PIX_W-1:0] mem [STORE_DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Forward a write that lands on the entry being read in the same cycle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fdmd_judge.sv =====
`timescale 1ns / 1ps

module fdmd_judge (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [fdmd_pkg::TRIG_W-1:0]    trigger,
    input  logic [fdmd_pkg::TOTAL_W-1:0]   total,
    input  logic [fdmd_pkg::PERSIST_W-1:0] persistence,
    input  fdmd_pkg::fin_t                 fin,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic                           alarm,
    output logic [fdmd_pkg::COUNT_W-1:0]   changed_count,
    output logic                           compared
);
    import fdmd_pkg::*;

    logic [RHS_W-1:0]     rhs_reg;
    logic [RHS_W-1:0]     rhs_lo;
    logic [RHS_W-1:0]     rhs_hi;
    logic [RHS_W-1:0]     lhs;
    logic [PERSIST_W-1:0] hit_reg;
    logic [PERSIST_W-1:0] hit_next;
    logic [PERSIST_W-1:0] need;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 alarm_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 compared_reg;

    // Split the trigger so the multiplier stays at 16 x 18
    assign rhs_lo = RHS_W'(trigger[15:0]) * RHS_W'(total);
    assign rhs_hi = trigger[16] ? RHS_W'({total, 16'h0000}) : '0;

    always_ff @(posedge clk)
    begin
        rhs_reg <= rhs_lo + rhs_hi;
    end

    assign lhs  = RHS_W'({fin.count, 16'h0000});
    assign need = (persistence == '0) ? PERSIST_W'(1) : persistence;

    always_comb
    begin
        hit_next = hit_reg;
        if (fin.valid)
        begin
            if (fin.compared && (lhs > rhs_reg))
            begin
                hit_next = (hit_reg == '1) ? hit_reg : hit_reg + 1'b1;
            end
            else
            begin
                hit_next = '0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin.valid)
        begin
            alarm_reg    <= fin.compared && (hit_next >= need);
            count_reg    <= fin.count;
            compared_reg <= fin.compared;
        end
    end

    assign out_valid     = out_valid_reg;
    assign alarm         = alarm_reg;
    assign changed_count = count_reg;
    assign compared      = compared_reg;

endmodule
